// ===== sv/midpoint_ellipse_rasterizer_defines.svh =====
// ---------------------------------------------------------------------------
// Midpoint ellipse rasterizer assertion macros
// Concurrent check wrappers; they expand to nothing for synthesis.
// ---------------------------------------------------------------------------
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_DEFINES_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_DEFINES_SVH

`ifndef SYNTHESIS
// check gated off while reset is high
`define MER_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check that also holds across reset
`define MER_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MER_ASSERT(lbl, clk, rst, prop, msg)
`define MER_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== sv/mer_pkg.sv =====
// ---------------------------------------------------------------------------
// Midpoint ellipse rasterizer package
// Action codes and the command/status bundles between controller and datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mer_pkg;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  typedef logic [3:0] mul_op_t;
  typedef logic [2:0] acc_op_t;
  typedef logic [1:0] pos_op_t;

  // multiplier operand select
  localparam mul_op_t MUL_NONE    = 4'd0;
  localparam mul_op_t MUL_RXRX    = 4'd1;  // rx2  <= rx * rx
  localparam mul_op_t MUL_RYRY    = 4'd2;  // ry2  <= ry * ry
  localparam mul_op_t MUL_RX2_RY  = 4'd3;  // prod <= rx2 * ry
  localparam mul_op_t MUL_TXTX    = 4'd4;  // prod <= (2x+1)^2
  localparam mul_op_t MUL_RY2_P   = 4'd5;  // prod <= ry2 * prod
  localparam mul_op_t MUL_TYTY    = 4'd6;  // prod <= (y-1)^2
  localparam mul_op_t MUL_RX2_P   = 4'd7;  // prod <= rx2 * prod
  localparam mul_op_t MUL_RX2_RY2 = 4'd8;  // prod <= rx2 * ry2

  // decision register update
  localparam acc_op_t ACC_NONE = 3'd0;
  localparam acc_op_t ACC_INIT = 3'd1;
  localparam acc_op_t ACC_R1   = 3'd2;
  localparam acc_op_t ACC_R2   = 3'd3;
  localparam acc_op_t ACC_LOAD = 3'd4;
  localparam acc_op_t ACC_ADD4 = 3'd5;
  localparam acc_op_t ACC_SUB4 = 3'd6;

  // offset and slope update
  localparam pos_op_t POS_NONE = 2'd0;
  localparam pos_op_t POS_INIT = 2'd1;
  localparam pos_op_t POS_R1   = 2'd2;
  localparam pos_op_t POS_R2   = 2'd3;

  typedef struct packed {
    logic    in_load;
    mul_op_t mul_op;
    acc_op_t acc_op;
    pos_op_t pos_op;
    logic    out_load;
    logic    out_zero;
  } cmd_t;

  typedef struct packed {
    logic slope_lt;  // slope_x < slope_y
    logic y_zero;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/mer_item_if.sv =====
// ---------------------------------------------------------------------------
// Midpoint ellipse rasterizer input channel
// Valid/ready channel carrying one start or step item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mer_item_if #(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 10
);
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic signed [COORD_BITS-1:0]  center_x;
  logic signed [COORD_BITS-1:0]  center_y;
  logic        [RADIUS_BITS-1:0] radius_x;
  logic        [RADIUS_BITS-1:0] radius_y;

  modport source (output valid, action, center_x, center_y, radius_x, radius_y,
                  input ready);
  modport sink   (input valid, action, center_x, center_y, radius_x, radius_y,
                  output ready);
endinterface

// ===== sv/mer_result_if.sv =====
// ---------------------------------------------------------------------------
// Midpoint ellipse rasterizer result channel
// Valid/ready channel carrying one set of four mirrored points.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mer_result_if #(
  parameter int COORD_BITS = 12
);
  logic                      valid;
  logic                      ready;
  logic                      valid_res;
  logic signed [COORD_BITS:0] point_a_x;
  logic signed [COORD_BITS:0] point_a_y;
  logic signed [COORD_BITS:0] point_b_x;
  logic signed [COORD_BITS:0] point_b_y;
  logic signed [COORD_BITS:0] point_c_x;
  logic signed [COORD_BITS:0] point_c_y;
  logic signed [COORD_BITS:0] point_d_x;
  logic signed [COORD_BITS:0] point_d_y;
  logic                      last;

  modport source (output valid, valid_res, point_a_x, point_a_y, point_b_x, point_b_y,
                  point_c_x, point_c_y, point_d_x, point_d_y, last,
                  input ready);
  modport sink   (input valid, valid_res, point_a_x, point_a_y, point_b_x, point_b_y,
                  point_c_x, point_c_y, point_d_x, point_d_y, last,
                  output ready);
endinterface

// ===== sv/midpoint_ellipse_rasterizer.sv =====
// ---------------------------------------------------------------------------
// Midpoint ellipse rasterizer
// Walks one quadrant of an ellipse and returns four mirrored points per item.
// ---------------------------------------------------------------------------
// Usage:
//   item   : valid/ready input. action = start (latch centre and radii) or
//            step (advance one point). Accepted when valid && ready.
//   result : valid/ready output, exactly one item per accepted input item.
//            A step with no ellipse in progress gives valid_res = 0 and zeros.
//   Sequence, accept to result valid:
//     start                    three multiplies, set-up, load
//     step in region 1 or 2    offset update, decision update and load
//     first step of region 2   set-up states M1 to M6, then a region 2 step
//     step while idle          result load only
//   One item is worked at a time; the next is taken once the controller is
//   back in idle after its result is loaded. The walk is limited by the
//   point-to-point dependence through the decision register.
//   The result register lets a new item be taken while a result waits.
//   Stall: if result is not taken, the finished point waits in the
//   controller until the result register frees; no item is accepted then.
//   Reset (rst, synchronous): returns to idle with no result pending.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module midpoint_ellipse_rasterizer #(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 10
) (
  input  logic                clk,
  input  logic                rst,
  mer_item_if.sink            item,
  mer_result_if.source        result
);

  mer_pkg::cmd_t cmd;
  mer_pkg::sts_t sts;

  // controller: phase, step sequencing, result hand-off
  mer_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_action (item.action),
    .in_ready  (item.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: shared multiplier, decision and slope registers, result register
  mer_datapath #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .center_x  (item.center_x),
    .center_y  (item.center_y),
    .radius_x  (item.radius_x),
    .radius_y  (item.radius_y),
    .out_ready (result.ready),
    .out_valid (result.valid),
    .valid_res (result.valid_res),
    .point_a_x (result.point_a_x),
    .point_a_y (result.point_a_y),
    .point_b_x (result.point_b_x),
    .point_b_y (result.point_b_y),
    .point_c_x (result.point_c_x),
    .point_c_y (result.point_c_y),
    .point_d_x (result.point_d_x),
    .point_d_y (result.point_d_y),
    .last      (result.last)
  );

endmodule

// ===== sv/mer_datapath.sv =====
// ---------------------------------------------------------------------------
// Midpoint ellipse rasterizer datapath
// Shared multiplier, decision/slope/offset registers and the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "midpoint_ellipse_rasterizer_defines.svh"

module mer_datapath #(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mer_pkg::cmd_t                 cmd,
  output mer_pkg::sts_t                 sts,
  input  logic signed [COORD_BITS-1:0]  center_x,
  input  logic signed [COORD_BITS-1:0]  center_y,
  input  logic        [RADIUS_BITS-1:0] radius_x,
  input  logic        [RADIUS_BITS-1:0] radius_y,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          valid_res,
  output logic signed [COORD_BITS:0]    point_a_x,
  output logic signed [COORD_BITS:0]    point_a_y,
  output logic signed [COORD_BITS:0]    point_b_x,
  output logic signed [COORD_BITS:0]    point_b_y,
  output logic signed [COORD_BITS:0]    point_c_x,
  output logic signed [COORD_BITS:0]    point_c_y,
  output logic signed [COORD_BITS:0]    point_d_x,
  output logic signed [COORD_BITS:0]    point_d_y,
  output logic                          last
);

  localparam int XW = RADIUS_BITS + 2;     // offsets, margin over the radius
  localparam int OW = COORD_BITS + 1;      // output coordinates
  localparam int MA = 2 * RADIUS_BITS;     // multiplier port A
  localparam int MB = 2 * (XW + 1);        // multiplier port B, holds (2x+1)^2
  localparam int PW = MA + MB;             // product
  localparam int SW = 3 * RADIUS_BITS + 4; // slope terms, signed
  localparam int DW = PW + 4;              // decision, signed

  logic signed [COORD_BITS-1:0]  cen_x, cen_y;
  logic        [RADIUS_BITS-1:0] rad_x, rad_y;
  logic        [MA-1:0]          rx2, ry2;
  logic        [PW-1:0]          prod;
  logic        [XW-1:0]          off_x, off_y;
  logic signed [SW-1:0]          slope_x, slope_y;
  logic signed [DW-1:0]          decision;

  logic        [MA-1:0]          mul_a;
  logic        [MB-1:0]          mul_b;
  logic        [PW-1:0]          product;
  logic        [XW:0]            tx;
  logic        [XW-1:0]          ty;
  logic                          dec_neg, dec_pos;
  logic signed [SW-1:0]          two_rx2, two_ry2;
  logic signed [DW-1:0]          rx2_d, ry2_d, prod_d, sx_d, sy_d;
  logic signed [DW-1:0]          r1_sub, r2_add, acc_term;

  assign tx = {off_x, 1'b1};
  assign ty = off_y - 1'b1;

  // operand select for the single multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul_op)
      mer_pkg::MUL_NONE: begin
      end
      mer_pkg::MUL_RXRX: begin
        mul_a = MA'(rad_x);
        mul_b = MB'(rad_x);
      end
      mer_pkg::MUL_RYRY: begin
        mul_a = MA'(rad_y);
        mul_b = MB'(rad_y);
      end
      mer_pkg::MUL_RX2_RY: begin
        mul_a = rx2;
        mul_b = MB'(rad_y);
      end
      mer_pkg::MUL_TXTX: begin
        mul_a = MA'(tx);
        mul_b = MB'(tx);
      end
      mer_pkg::MUL_RY2_P: begin
        mul_a = ry2;
        mul_b = prod[MB-1:0];
      end
      mer_pkg::MUL_TYTY: begin
        mul_a = MA'(ty);
        mul_b = MB'(ty);
      end
      mer_pkg::MUL_RX2_P: begin
        mul_a = rx2;
        mul_b = prod[MB-1:0];
      end
      mer_pkg::MUL_RX2_RY2: begin
        mul_a = rx2;
        mul_b = MB'(ry2);
      end
      default: begin
      end
    endcase
  end

  assign product = PW'(mul_a) * PW'(mul_b);

  assign dec_neg = decision[DW-1];
  assign dec_pos = !decision[DW-1] && (decision != '0);

  assign two_rx2 = $signed(SW'(rx2)) <<< 1;
  assign two_ry2 = $signed(SW'(ry2)) <<< 1;
  assign rx2_d   = $signed(DW'(rx2));
  assign ry2_d   = $signed(DW'(ry2));
  assign prod_d  = $signed(DW'(prod));
  assign sx_d    = DW'(slope_x);
  assign sy_d    = DW'(slope_y);

  always_comb begin
    r1_sub   = dec_neg ? '0 : sy_d;
    r2_add   = dec_pos ? '0 : sx_d;
    acc_term = '0;
    unique case (cmd.acc_op)
      mer_pkg::ACC_INIT: acc_term = (ry2_d <<< 2) - (prod_d <<< 2) + rx2_d;
      mer_pkg::ACC_R1:   acc_term = decision + ((ry2_d + sx_d - r1_sub) <<< 2);
      mer_pkg::ACC_R2:   acc_term = decision + ((rx2_d - sy_d + r2_add) <<< 2);
      mer_pkg::ACC_LOAD: acc_term = prod_d;
      mer_pkg::ACC_ADD4: acc_term = decision + (prod_d <<< 2);
      mer_pkg::ACC_SUB4: acc_term = decision - (prod_d <<< 2);
      default:           acc_term = decision;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      cen_x <= center_x;
      cen_y <= center_y;
      rad_x <= radius_x;
      rad_y <= radius_y;
    end

    case (cmd.mul_op)
      mer_pkg::MUL_NONE: begin
      end
      mer_pkg::MUL_RXRX: rx2  <= product[MA-1:0];
      mer_pkg::MUL_RYRY: ry2  <= product[MA-1:0];
      default:           prod <= product;
    endcase

    if (cmd.acc_op != mer_pkg::ACC_NONE) begin
      decision <= acc_term;
    end

    unique case (cmd.pos_op)
      mer_pkg::POS_NONE: begin
      end
      mer_pkg::POS_INIT: begin
        off_x   <= '0;
        off_y   <= XW'(rad_y);
        slope_x <= '0;
        slope_y <= $signed(SW'(prod)) <<< 1;
      end
      mer_pkg::POS_R1: begin
        off_x   <= off_x + 1'b1;
        slope_x <= slope_x + two_ry2;
        if (!dec_neg) begin
          off_y   <= off_y - 1'b1;
          slope_y <= slope_y - two_rx2;
        end
      end
      mer_pkg::POS_R2: begin
        off_y   <= off_y - 1'b1;
        slope_y <= slope_y - two_rx2;
        if (!dec_pos) begin
          off_x   <= off_x + 1'b1;
          slope_x <= slope_x + two_ry2;
        end
      end
      default: begin
      end
    endcase
  end

  // result register; coordinates wrap to OW bits
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_zero) begin
        valid_res <= 1'b0;
        point_a_x <= '0;
        point_a_y <= '0;
        point_b_x <= '0;
        point_b_y <= '0;
        point_c_x <= '0;
        point_c_y <= '0;
        point_d_x <= '0;
        point_d_y <= '0;
        last      <= 1'b0;
      end else begin
        valid_res <= 1'b1;
        point_a_x <= OW'(cen_x) + OW'(off_x);
        point_a_y <= OW'(cen_y) + OW'(off_y);
        point_b_x <= OW'(cen_x) + OW'(off_x);
        point_b_y <= OW'(cen_y) - OW'(off_y);
        point_c_x <= OW'(cen_x) - OW'(off_x);
        point_c_y <= OW'(cen_y) - OW'(off_y);
        point_d_x <= OW'(cen_x) - OW'(off_x);
        point_d_y <= OW'(cen_y) + OW'(off_y);
        last      <= (off_y == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign sts.slope_lt = (slope_x < slope_y);
  assign sts.y_zero   = (off_y == '0);
  assign sts.out_free = !out_valid || out_ready;

  `MER_ASSERT(a_r1_only_below_slope, clk, rst,
    (cmd.pos_op == mer_pkg::POS_R1) |-> sts.slope_lt, "region 1 step past slope crossing")
  `MER_ASSERT(a_r2_y_positive, clk, rst,
    (cmd.pos_op == mer_pkg::POS_R2) |-> !sts.y_zero, "region 2 step with y already zero")
  `MER_ASSERT(a_r1_x_advances, clk, rst,
    (cmd.pos_op == mer_pkg::POS_R1) |=> (off_x == XW'($past(off_x) + 1'b1)), "x not advanced")
  `MER_ASSERT(a_load_into_free, clk, rst,
    cmd.out_load |-> sts.out_free, "result overwritten before taken")

endmodule

// ===== sv/mer_ctrl.sv =====
// ---------------------------------------------------------------------------
// Midpoint ellipse rasterizer controller
// Sequences start set-up, region steps, region 2 set-up and result hand-off.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "midpoint_ellipse_rasterizer_defines.svh"

module mer_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_action,
  output logic          in_ready,
  input  mer_pkg::sts_t sts,
  output mer_pkg::cmd_t cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQX  = 4'd1;
  localparam logic [3:0] S_SQY  = 4'd2;
  localparam logic [3:0] S_RXRY = 4'd3;
  localparam logic [3:0] S_INIT = 4'd4;
  localparam logic [3:0] S_EMIT = 4'd5;
  localparam logic [3:0] S_R1A  = 4'd6;
  localparam logic [3:0] S_R1B  = 4'd7;
  localparam logic [3:0] S_M1   = 4'd8;
  localparam logic [3:0] S_M2   = 4'd9;
  localparam logic [3:0] S_M3   = 4'd10;
  localparam logic [3:0] S_M4   = 4'd11;
  localparam logic [3:0] S_M5   = 4'd12;
  localparam logic [3:0] S_M6   = 4'd13;
  localparam logic [3:0] S_R2A  = 4'd14;
  localparam logic [3:0] S_R2B  = 4'd15;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_REG1 = 2'd1;
  localparam logic [1:0] PH_REG2 = 2'd2;

  logic [3:0] state, state_next;
  logic [1:0] phase;
  logic       accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_action == mer_pkg::ACT_START) begin
            cmd.in_load = 1'b1;
            state_next  = S_SQX;
          end else if (phase == PH_IDLE) begin
            state_next = S_EMIT;
          end else if (phase == PH_REG1 && sts.slope_lt) begin
            state_next = S_R1A;
          end else if (phase == PH_REG1) begin
            state_next = S_M1;
          end else begin
            state_next = S_R2A;
          end
        end
      end
      S_SQX: begin
        cmd.mul_op = mer_pkg::MUL_RXRX;
        state_next = S_SQY;
      end
      S_SQY: begin
        cmd.mul_op = mer_pkg::MUL_RYRY;
        state_next = S_RXRY;
      end
      S_RXRY: begin
        cmd.mul_op = mer_pkg::MUL_RX2_RY;
        state_next = S_INIT;
      end
      S_INIT: begin
        cmd.pos_op = mer_pkg::POS_INIT;
        cmd.acc_op = mer_pkg::ACC_INIT;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_zero = (phase == PH_IDLE);
          state_next   = S_IDLE;
        end
      end
      S_R1A: begin
        cmd.pos_op = mer_pkg::POS_R1;
        state_next = S_R1B;
      end
      S_R1B: begin
        cmd.acc_op = mer_pkg::ACC_R1;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_M1: begin
        cmd.mul_op = mer_pkg::MUL_TXTX;
        state_next = S_M2;
      end
      S_M2: begin
        cmd.mul_op = mer_pkg::MUL_RY2_P;
        state_next = S_M3;
      end
      S_M3: begin
        cmd.mul_op = mer_pkg::MUL_TYTY;
        cmd.acc_op = mer_pkg::ACC_LOAD;
        state_next = S_M4;
      end
      S_M4: begin
        cmd.mul_op = mer_pkg::MUL_RX2_P;
        state_next = S_M5;
      end
      S_M5: begin
        cmd.mul_op = mer_pkg::MUL_RX2_RY2;
        cmd.acc_op = mer_pkg::ACC_ADD4;
        state_next = S_M6;
      end
      S_M6: begin
        cmd.acc_op = mer_pkg::ACC_SUB4;
        state_next = S_R2A;
      end
      S_R2A: begin
        cmd.pos_op = mer_pkg::POS_R2;
        state_next = S_R2B;
      end
      S_R2B: begin
        cmd.acc_op = mer_pkg::ACC_R2;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end else begin
          state_next = S_EMIT;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_IDLE;
    end else begin
      state <= state_next;
      if (state == S_INIT) begin
        phase <= PH_REG1;
      end else if (state == S_M6) begin
        phase <= PH_REG2;
      end else if (cmd.out_load && !cmd.out_zero && sts.y_zero) begin
        phase <= PH_IDLE;
      end
    end
  end

  `MER_ASSERT_ALWAYS(a_reset_state, clk,
    rst |=> (state == S_IDLE && phase == PH_IDLE), "reset did not clear controller")
  `MER_ASSERT(a_load_then_idle, clk, rst,
    cmd.out_load |=> (state == S_IDLE), "no return to idle after result")
  `MER_ASSERT(a_reg2_entry, clk, rst,
    (phase == PH_REG2 && $past(phase) != PH_REG2) |-> ($past(state) == S_M6),
    "region 2 entered without set-up")
  `MER_ASSERT(a_no_accept_on_load, clk, rst,
    accept |-> !cmd.out_load, "item accepted while result loads")

endmodule
